/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Plain invariant.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`endif

/* rtl/core/rau_pkg.sv */
// Package: modes, status codes, controller states and command structs.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int unsigned NumW = 32;
  localparam int unsigned DenW = 31;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDEF = 2'd1,
    ST_OVF   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_GCD,
    S_DIV,
    S_DONE
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic mul;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_done;
  } sts_t;
endpackage

/* rtl/core/rau_ctrl.sv */
// Controller state machine sequencing the rational datapath.
`timescale 1ns / 1ps
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rau_pkg::sts_t sts_i,
  output rau_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  import rau_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        if (sts_i.special) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul      = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        done_o       = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

/* rtl/core/rau_dp.sv */
// Datapath: operand decode, cross products, binary gcd and restoring division.
`timescale 1ns / 1ps
module rau_dp #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                 clk_i,
  input  rau_pkg::cmd_t        cmd_i,
  output rau_pkg::sts_t        sts_o,
  input  logic [2:0]           mode_i,
  input  logic signed [31:0]   a_num_i,
  input  logic [30:0]          a_den_i,
  input  logic signed [31:0]   b_num_i,
  input  logic [30:0]          b_den_i,
  output logic signed [31:0]   res_num_o,
  output logic [30:0]          res_den_o,
  output logic                 less_o,
  output logic                 equal_o,
  output logic                 greater_o,
  output logic [1:0]           status_o
);
  import rau_pkg::*;

  localparam int unsigned EW = (WIDTH < 32) ? WIDTH : 32;
  // Magnitudes up to 2^31 * 2^31 * 2 fit in 64 bits.
  localparam int unsigned MW = 64;
  localparam int unsigned CW = 7;

  logic [2:0]         mode_q;
  logic signed [32:0] an_q, bn_q;
  logic [30:0]        ad_q, bd_q;
  logic [MW-1:0]      mag_q, den_q, gx_q, gy_q, quo_q, rem_q;
  logic               neg_q;
  logic [CW-1:0]      cnt_q;
  logic [6:0]         shf_q;
  logic               ovf_q, undef_q;
  logic signed [32:0] snum_q;
  logic [30:0]        sden_q;
  logic               lt_q, eq_q, gt_q;
  logic               divden_q;

  // Operand decode after load, with the effective second operand.
  // The reciprocal of -2^31 needs a 32-bit denominator.
  logic a_nan, b_nan, a_inf, b_inf, b_zero, a_zero, rb_nan, rb_inf, rb_zero;
  logic signed [32:0] rbn;
  logic [31:0] rbd;
  logic special;
  logic signed [32:0] sp_num;
  logic sp_undef, sp_cmp;

  always_comb begin
    rbn = bn_q;
    rbd = {1'b0, bd_q};
    a_nan = (ad_q == '0) && (an_q == '0);
    a_inf = (ad_q == '0) && (an_q != '0);
    a_zero = (an_q == '0);
    b_nan = (bd_q == '0) && (bn_q == '0);
    b_zero = (bn_q == '0);
    if (mode_q == MODE_SUB) begin
      rbn = -bn_q;
    end else if (mode_q == MODE_DIV) begin
      if (b_nan) begin
        rbn = bn_q;
      end else if (bd_q == '0) begin
        rbn = 33'sd0;
        rbd = 32'd1;
      end else if (b_zero) begin
        rbn = 33'sd1;
        rbd = '0;
      end else if (bn_q > 0) begin
        rbn = {2'b00, bd_q};
        rbd = bn_q[31:0];
      end else begin
        rbn = -$signed({2'b00, bd_q});
        rbd = 32'(-bn_q);
      end
    end
    rb_nan  = (rbd == '0) && (rbn == '0);
    rb_inf  = (rbd == '0) && (rbn != '0);
    rb_zero = (rbn == '0);
    b_inf   = (bd_q == '0) && (bn_q != '0);
    special  = 1'b1;
    sp_num   = '0;
    sp_undef = 1'b0;
    sp_cmp   = 1'b0;
    case (mode_q) inside
      MODE_ADD, MODE_SUB: begin
        if (a_nan || rb_nan) begin
          sp_undef = 1'b1;
        end else if (a_inf && rb_inf) begin
          if (an_q[32] == rbn[32]) sp_num = an_q[32] ? -33'sd1 : 33'sd1;
          else sp_undef = 1'b1;
        end else if (a_inf) begin
          sp_num = an_q[32] ? -33'sd1 : 33'sd1;
        end else if (rb_inf) begin
          sp_num = rbn[32] ? -33'sd1 : 33'sd1;
        end else begin
          special = 1'b0;
        end
      end
      MODE_MUL, MODE_DIV: begin
        if (a_nan || rb_nan) begin
          sp_undef = 1'b1;
        end else if (a_inf || rb_inf) begin
          if (a_zero || rb_zero) sp_undef = 1'b1;
          else sp_num = (an_q[32] != rbn[32]) ? -33'sd1 : 33'sd1;
        end else begin
          special = 1'b0;
        end
      end
      MODE_CMP: begin
        if (a_nan || b_nan) sp_undef = 1'b1;
        else sp_cmp = 1'b1;
      end
      default: sp_undef = 1'b1;
    endcase
  end

  // Compare: classes, then a cross product compare for finite pairs.
  logic signed [1:0] ca, cb;
  logic signed [64:0] xl, xr;
  logic c_lt, c_gt;
  always_comb begin
    ca = a_inf ? (an_q[32] ? -2'sd1 : 2'sd1) : 2'sd0;
    cb = b_inf ? (bn_q[32] ? -2'sd1 : 2'sd1) : 2'sd0;
    xl = an_q * $signed({2'b00, bd_q});
    xr = bn_q * $signed({2'b00, ad_q});
    if (ca != cb) begin
      c_lt = ca < cb;
      c_gt = !c_lt;
    end else if (ca == 0) begin
      c_lt = xl < xr;
      c_gt = xl > xr;
    end else begin
      c_lt = 1'b0;
      c_gt = 1'b0;
    end
  end

  // Cross products for add or multiply; the widest multiplier is 33 x 34.
  logic signed [65:0] p1, p2, nsum;
  logic [62:0] dprod;
  always_comb begin
    p1 = an_q * $signed({2'b00, rbd});
    p2 = rbn * $signed({2'b00, ad_q});
    dprod = ad_q * rbd;
    if (mode_q == MODE_MUL || mode_q == MODE_DIV) begin
      nsum = an_q * rbn;
    end else begin
      nsum = p1 + p2;
    end
  end

  // Binary gcd step: strip shared twos, halve an even side, else subtract.
  logic gcd_fin;
  assign gcd_fin = (gx_q == '0) || (gy_q == '0) || (gx_q == gy_q);
  logic [MW-1:0] g_val;
  assign g_val = ((gx_q == '0) ? gy_q : gx_q) << shf_q;

  // Restoring divider, both quotients share one counter through two rows.
  logic [MW:0] trial;
  assign trial = {rem_q, quo_q[MW-1]} - {1'b0, gx_q};

  assign sts_o.special  = special;
  assign sts_o.gcd_done = gcd_fin;
  assign sts_o.div_done = divden_q && (cnt_q == '0);

  logic [MW-1:0] lim;
  assign lim = MW'(1) << (EW - 1);

  // Result values captured on finish.
  logic               lt_d, eq_d, gt_d, ovf_d, undef_d;
  logic signed [32:0] snum_d;
  logic [30:0]        sden_d;
  always_comb begin
    lt_d    = 1'b0;
    eq_d    = 1'b0;
    gt_d    = 1'b0;
    snum_d  = '0;
    sden_d  = '0;
    ovf_d   = 1'b0;
    undef_d = 1'b0;
    if (special) begin
      if (sp_undef) begin
        undef_d = 1'b1;
      end else if (sp_cmp) begin
        lt_d = c_lt;
        gt_d = c_gt;
        eq_d = !c_lt && !c_gt;
      end else begin
        snum_d = sp_num;
      end
    end else if ((neg_q ? mag_q > lim : mag_q > lim - 1) || quo_q > lim - 1) begin
      ovf_d = 1'b1;
    end else begin
      snum_d = neg_q ? -$signed({1'b0, mag_q[31:0]}) : $signed({1'b0, mag_q[31:0]});
      sden_d = quo_q[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      an_q   <= 33'(a_num_i);
      ad_q   <= a_den_i;
      bn_q   <= 33'(b_num_i);
      bd_q   <= b_den_i;
    end
    if (cmd_i.mul) begin
      neg_q <= nsum[65];
      mag_q <= nsum[65] ? MW'(-nsum) : MW'(nsum);
      den_q <= MW'(dprod);
      gx_q  <= nsum[65] ? MW'(-nsum) : MW'(nsum);
      gy_q  <= MW'(dprod);
      shf_q <= '0;
    end
    if (cmd_i.gcd_step) begin
      if (!gx_q[0] && !gy_q[0]) begin
        gx_q <= gx_q >> 1;
        gy_q <= gy_q >> 1;
        shf_q <= shf_q + 7'd1;
      end else if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (!gy_q[0]) begin
        gy_q <= gy_q >> 1;
      end else if (gx_q > gy_q) begin
        gx_q <= gx_q - gy_q;
      end else begin
        gy_q <= gy_q - gx_q;
      end
    end
    if (cmd_i.div_init) begin
      gx_q     <= g_val;
      quo_q    <= mag_q;
      rem_q    <= '0;
      cnt_q    <= CW'(MW);
      divden_q <= 1'b0;
    end
    if (cmd_i.div_step) begin
      if (cnt_q == CW'(1) && !divden_q) begin
        // First row done: keep numerator quotient, start on the denominator.
        mag_q    <= trial[MW] ? {quo_q[MW-2:0], 1'b0} : {quo_q[MW-2:0], 1'b1};
        quo_q    <= den_q;
        rem_q    <= '0;
        cnt_q    <= CW'(MW);
        divden_q <= 1'b1;
      end else begin
        if (trial[MW]) begin
          rem_q <= {rem_q[MW-2:0], quo_q[MW-1]};
          quo_q <= {quo_q[MW-2:0], 1'b0};
        end else begin
          rem_q <= trial[MW-1:0];
          quo_q <= {quo_q[MW-2:0], 1'b1};
        end
        cnt_q <= cnt_q - CW'(1);
      end
    end
    if (cmd_i.finish) begin
      lt_q    <= lt_d;
      eq_q    <= eq_d;
      gt_q    <= gt_d;
      snum_q  <= snum_d;
      sden_q  <= sden_d;
      ovf_q   <= ovf_d;
      undef_q <= undef_d;
    end
  end

  assign res_num_o = snum_q[31:0];
  assign res_den_o = sden_q;
  assign less_o    = lt_q;
  assign equal_o   = eq_q;
  assign greater_o = gt_q;
  assign status_o  = undef_q ? ST_UNDEF : (ovf_q ? ST_OVF : ST_OK);
endmodule

/* rtl/core/rational_arithmetic_unit.sv */
// Top level of the exact rational arithmetic unit.
//   channel  | signals                                   | handshake
//   command  | mode_i a_num_i a_den_i b_num_i b_den_i      | start_i && !busy_o
//   result   | res_num_o res_den_o less_o equal_o ...      | done_o strobe, 1 cycle
// Specials and compare pass from accept through S_MUL straight to S_DONE;
// finite add/sub/mul/div pass S_MUL, the S_GCD steps of the binary gcd unit
// and S_DIV, the restoring divider (two 64-bit quotients), before S_DONE.
// Reset clears only the controller and the done_o register; result registers are loaded per item.
// The receiver cannot stall: done_o is a one-cycle strobe.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] a_num_i,
  input  logic [30:0]        a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic [30:0]        b_den_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic               less_o,
  output logic               equal_o,
  output logic               greater_o,
  output logic [1:0]         status_o
);
  import rau_pkg::*;
  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;
  logic done_int;

  rau_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_int)
  );

  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .mode_i   (mode_i),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .res_num_o(res_num_o),
    .res_den_o(res_den_o),
    .less_o   (less_o),
    .equal_o  (equal_o),
    .greater_o(greater_o),
    .status_o (status_o)
  );

  // Results are registered on finish, shown the cycle after.
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_int;
    end
  end
  assign done_o = done_q;

  `ASSERT_IMPL(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "done_o longer than a cycle")
  `ASSERT_IMPL(a_start_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "accept without busy")
  `ASSERT_ALWAYS(a_one_flag, clk_i, rst_ni, !done_o || $onehot0({less_o, equal_o, greater_o}),
    "several compare flags")
endmodule
